// ===== design/lwbc_pkg.sv =====
// Shared types and constants for the write-back block cache tag controller.
// No dependencies; every other file in design/ imports this package.
package lwbc_pkg;

  localparam int unsigned TAG_W      = 52;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned WAYS_DEF   = 16;
  localparam int unsigned WAYS_MAX   = 64;
  localparam int unsigned SLOT_IDX_W = $clog2(WAYS_MAX);

  localparam logic [STAMP_W-1:0] STAMP_TOP = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_INVAL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } st_e;

  // Record that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic                  active;
    logic                  flush;
    logic                  is_write;
    logic                  full;
    logic [TAG_W-1:0]      tag;
    logic                  found;
    logic [SLOT_IDX_W-1:0] fidx;
    logic [SLOT_IDX_W-1:0] vidx;
    logic [STAMP_W-1:0]    best;
    logic [TAG_W-1:0]      vtag;
    logic                  vwb;
    logic                  more;
  } rec_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                  en;
    logic                  clr;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  new_tag;
    logic [TAG_W-1:0]      tag;
    logic [STAMP_W-1:0]    stamp;
    logic                  is_write;
  } cmd_t;

endpackage

// ===== design/lwbc_cell.sv =====
// One cache slot: tag, valid, dirty and use stamp, plus one stage of the
// lookup record. Depends on lwbc_pkg.
module lwbc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lwbc_pkg::rec_t rec_i,
  input  lwbc_pkg::cmd_t cmd_i,
  output lwbc_pkg::rec_t rec_o
);
  import lwbc_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(IDX);

  logic [TAG_W-1:0]   tag_q;
  logic               valid_q;
  logic               dirty_q;
  logic [STAMP_W-1:0] stamp_q;
  rec_t               rec_q, rec_d;
  logic               hit_here, qual, claim;

  assign hit_here = valid_q && (tag_q == rec_i.tag);
  assign qual     = valid_q && (rec_i.is_write || !dirty_q) && (stamp_q < rec_i.best);

  always_comb begin
    rec_d = rec_i;
    claim = 1'b0;
    if (rec_i.active) begin
      if (rec_i.flush) begin
        if (valid_q && dirty_q) begin
          if (!rec_i.found) begin
            rec_d.found = 1'b1;
            rec_d.fidx  = MY_IDX;
            rec_d.vtag  = tag_q;
            claim       = 1'b1;
          end else begin
            rec_d.more = 1'b1;
          end
        end
      end else if (!rec_i.found) begin
        if (hit_here) begin
          rec_d.found = 1'b1;
          rec_d.fidx  = MY_IDX;
        end else if (!valid_q || qual || (IDX == 0)) begin
          // slot 0 is the fallback victim even when it does not qualify
          rec_d.vidx = MY_IDX;
          rec_d.vtag = tag_q;
          rec_d.vwb  = valid_q && dirty_q;
          if (!valid_q) begin
            rec_d.best = '0;
          end else if (qual) begin
            rec_d.best = stamp_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      stamp_q <= '0;
    end else if (cmd_i.clr) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      stamp_q <= '0;
    end else if (cmd_i.en && (cmd_i.idx == MY_IDX)) begin
      valid_q <= 1'b1;
      stamp_q <= cmd_i.stamp;
      if (cmd_i.new_tag) begin
        tag_q <= cmd_i.tag;
      end
      if (cmd_i.is_write) begin
        dirty_q <= 1'b1;
      end else if (cmd_i.new_tag) begin
        dirty_q <= 1'b0;
      end
    end else if (claim) begin
      dirty_q <= 1'b0;
    end
  end

  assign rec_o = rec_q;

endmodule

// ===== design/lwbc_ctrl.sv =====
// Sequencer: takes items, launches records into the cell row, turns the
// returning record into a result and holds it in the output register.
// Depends on lwbc_pkg.
module lwbc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 opcode_i,
  input  logic [lwbc_pkg::TAG_W-1:0] block_number_i,
  input  logic                       full_block_i,
  output lwbc_pkg::rec_t             launch_o,
  input  lwbc_pkg::rec_t             tail_i,
  output lwbc_pkg::cmd_t             cmd_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic [lwbc_pkg::SLOT_W-1:0] slot_o,
  output logic                       writeback_needed_o,
  output logic [lwbc_pkg::TAG_W-1:0] writeback_block_o,
  output logic                       fill_needed_o,
  output logic                       last_o
);
  import lwbc_pkg::*;

  st_e                st_q, st_d;
  rec_t               launch_q, launch_d;
  logic [STAMP_W-1:0] use_clock_q, use_clock_d;
  op_e                op;
  logic               in_acc, out_load;
  logic [SLOT_IDX_W-1:0] tgt;

  // pending result between the tail of the row and the output register
  logic               r_hit_q, r_hit_d;
  logic [SLOT_W-1:0]  r_slot_q, r_slot_d;
  logic               r_wb_q, r_wb_d;
  logic [TAG_W-1:0]   r_wbb_q, r_wbb_d;
  logic               r_fill_q, r_fill_d;
  logic               r_last_q, r_last_d;
  logic               r_more_q, r_more_d;

  logic               out_valid_q;
  logic               hit_q, wb_q, fill_q, last_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TAG_W-1:0]   wbb_q;

  assign op         = op_e'(opcode_i);
  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (st_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign tgt        = tail_i.found ? tail_i.fidx : tail_i.vidx;

  always_comb begin
    st_d        = st_q;
    launch_d    = '0;
    use_clock_d = use_clock_q;
    cmd_o       = '0;
    r_hit_d     = r_hit_q;
    r_slot_d    = r_slot_q;
    r_wb_d      = r_wb_q;
    r_wbb_d     = r_wbb_q;
    r_fill_d    = r_fill_q;
    r_last_d    = r_last_q;
    r_more_d    = r_more_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (op inside {OP_READ, OP_WRITE, OP_FLUSH}) begin
            launch_d.active   = 1'b1;
            launch_d.flush    = (op == OP_FLUSH);
            launch_d.is_write = (op == OP_WRITE);
            launch_d.full     = full_block_i;
            launch_d.tag      = block_number_i;
            launch_d.best     = STAMP_TOP;
            st_d              = ST_SCAN;
          end else begin
            cmd_o.clr   = 1'b1;
            use_clock_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (tail_i.active) begin
          if (tail_i.flush) begin
            r_hit_d  = 1'b0;
            r_slot_d = tail_i.fidx[SLOT_W-1:0];
            r_wb_d   = 1'b1;
            r_wbb_d  = tail_i.vtag;
            r_fill_d = 1'b0;
            r_last_d = !tail_i.more;
            r_more_d = tail_i.more;
            st_d     = tail_i.found ? ST_EMIT : ST_IDLE;
          end else begin
            use_clock_d    = use_clock_q + 1'b1;
            cmd_o.en       = 1'b1;
            cmd_o.idx      = tgt;
            cmd_o.new_tag  = !tail_i.found;
            cmd_o.tag      = tail_i.tag;
            cmd_o.stamp    = use_clock_q + 1'b1;
            cmd_o.is_write = tail_i.is_write;
            r_hit_d  = tail_i.found;
            r_slot_d = tgt[SLOT_W-1:0];
            r_wb_d   = !tail_i.found && tail_i.vwb;
            r_wbb_d  = (!tail_i.found && tail_i.vwb) ? tail_i.vtag : '0;
            r_fill_d = !tail_i.found && (!tail_i.is_write || !tail_i.full);
            r_last_d = 1'b1;
            r_more_d = 1'b0;
            st_d     = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (r_more_q) begin
            // emitted slot is already clean, so a fresh pass finds the next
            launch_d.active = 1'b1;
            launch_d.flush  = 1'b1;
            launch_d.best   = STAMP_TOP;
            st_d            = ST_SCAN;
          end else begin
            st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      launch_q    <= '0;
      use_clock_q <= '0;
      r_more_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      launch_q    <= launch_d;
      use_clock_q <= use_clock_d;
      r_more_q    <= r_more_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_hit_q  <= r_hit_d;
    r_slot_q <= r_slot_d;
    r_wb_q   <= r_wb_d;
    r_wbb_q  <= r_wbb_d;
    r_fill_q <= r_fill_d;
    r_last_q <= r_last_d;
    if (out_load) begin
      hit_q  <= r_hit_q;
      slot_q <= r_slot_q;
      wb_q   <= r_wb_q;
      wbb_q  <= r_wbb_q;
      fill_q <= r_fill_q;
      last_q <= r_last_q;
    end
  end

  assign launch_o           = launch_q;
  assign out_valid_o        = out_valid_q;
  assign hit_o              = hit_q;
  assign slot_o             = slot_q;
  assign writeback_needed_o = wb_q;
  assign writeback_block_o  = wbb_q;
  assign fill_needed_o      = fill_q;
  assign last_o             = last_q;

  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_i.active |-> (st_q == ST_SCAN))
    else $error("record left the cell row outside of a scan");

  a_inval_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == OP_INVAL)) |=> (use_clock_q == '0) && !in_stall_o)
    else $error("invalidate did not reset the use clock");

  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && r_hit_q) |=> !writeback_needed_o && !fill_needed_o)
    else $error("hit result asks for device traffic");

  a_wb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (writeback_needed_o || (writeback_block_o == '0)))
    else $error("write-back block set without write-back");

endmodule

// ===== design/lru_write_back_block_cache.sv =====
// Top level of the fully associative write-back block cache tag controller.
// Builds the row of slot cells and the sequencer; depends on lwbc_pkg,
// lwbc_cell and lwbc_ctrl.
//
//   channel  direction  handshake               payload
//   in       to block   in_valid_i / in_stall_o  opcode_i, block_number_i, full_block_i
//   out      from block out_valid_o / out_stall_i hit_o, slot_o, writeback_needed_o,
//                                                writeback_block_o, fill_needed_o, last_o
//
// Read or write: the lookup record walks the cell row one slot per cycle.
// Flush: one pass of the row per dirty slot; with no dirty slot a single pass.
// Invalidate gives no item.
// Reset makes every slot invalid and clean at once; no clearing pass.
// Output stall only delays the emit step of each result; a finished item may
// sit in the output register while the next input item is taken.
module lru_write_back_block_cache #(
  parameter int unsigned WAYS = lwbc_pkg::WAYS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [lwbc_pkg::TAG_W-1:0]  block_number_i,
  input  logic                        full_block_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic [lwbc_pkg::SLOT_W-1:0] slot_o,
  output logic                        writeback_needed_o,
  output logic [lwbc_pkg::TAG_W-1:0]  writeback_block_o,
  output logic                        fill_needed_o,
  output logic                        last_o
);
  import lwbc_pkg::*;

  rec_t rec[WAYS+1];
  cmd_t cmd;

  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    lwbc_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .rec_i (rec[g]),
      .cmd_i (cmd),
      .rec_o (rec[g+1])
    );
  end

  lwbc_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .block_number_i    (block_number_i),
    .full_block_i      (full_block_i),
    .launch_o          (rec[0]),
    .tail_i            (rec[WAYS]),
    .cmd_o             (cmd),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_o             (hit_o),
    .slot_o            (slot_o),
    .writeback_needed_o(writeback_needed_o),
    .writeback_block_o (writeback_block_o),
    .fill_needed_o     (fill_needed_o),
    .last_o            (last_o)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lru_write_back_block_cache: a directed table, then
// random block accesses, with random idling on both channels.
// Depends on lwbc_pkg and the cache top level.
module tb_top;
  import lwbc_pkg::*;

  localparam int unsigned NWAYS        = WAYS_DEF;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = NWAYS * (NWAYS + 2) + 8;
  localparam int unsigned RAND_ITEMS   = 230;
  localparam int unsigned POOL_SIZE    = 24;

  localparam logic [TAG_W-1:0] TAG_MAX   = '1;
  localparam logic [TAG_W-1:0] TAG_FIVES = 52'h5_5555_5555_5555;
  localparam logic [TAG_W-1:0] TAG_TENS  = 52'hA_AAAA_AAAA_AAAA;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              wb;
    logic [TAG_W-1:0]  wb_block;
    logic              fill;
    logic              last;
  } result_t;

  typedef struct packed {
    op_e              op;
    logic [TAG_W-1:0] blk;
    logic             full;
    logic             typed;  // want holds a hand-written result
    result_t          want;
  } block_op_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           opcode_i       = OP_READ;
  logic [TAG_W-1:0]     block_number_i = '0;
  logic                 full_block_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic                 hit_o;
  logic [SLOT_W-1:0]    slot_o;
  logic                 writeback_needed_o;
  logic [TAG_W-1:0]     writeback_block_o;
  logic                 fill_needed_o;
  logic                 last_o;

  // shadow copy of the slot store
  logic [TAG_W-1:0]   sh_tag   [NWAYS];
  logic               sh_valid [NWAYS];
  logic               sh_dirty [NWAYS];
  logic [STAMP_W-1:0] sh_stamp [NWAYS];
  logic [STAMP_W-1:0] sh_clock;

  block_op_t stim_q[$];
  block_op_t dir_tbl[$];
  result_t   pending_results[$];
  block_op_t cur_op;

  int  err_cnt    = 0;
  int  idle_cnt   = 0;
  int  in_gap     = 0;
  int  stall_left = 0;
  int  calm_cnt[2] = '{0, 0};
  bit  drained    = 1'b0;
  bit  timed_out  = 1'b0;

  lru_write_back_block_cache dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .block_number_i,
    .full_block_i, .out_valid_o, .out_stall_i, .hit_o, .slot_o,
    .writeback_needed_o, .writeback_block_o, .fill_needed_o, .last_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < NWAYS; i++) begin
      sh_tag[i]   = '0;
      sh_valid[i] = 1'b0;
      sh_dirty[i] = 1'b0;
      sh_stamp[i] = '0;
    end
    sh_clock = '0;
  end

  function automatic logic [TAG_W-1:0] rand_tag();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TAG_W-1:0];
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int pick_gap(input int side);
    int r;
    if (calm_cnt[side] > 0) begin
      calm_cnt[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_cnt[side] = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic block_op_t row(input op_e op, input logic [TAG_W-1:0] blk,
                                    input logic full, input logic typed,
                                    input logic hit, input logic [SLOT_W-1:0] slot,
                                    input logic fill);
    block_op_t b;
    b = '0;
    b.op = op;
    b.blk = blk;
    b.full = full;
    b.typed = typed;
    b.want.hit = hit;
    b.want.slot = slot;
    b.want.fill = fill;
    b.want.last = 1'b1;
    return b;
  endfunction

  // Updates the shadow store for one accepted item and queues its results.
  function automatic void track_block_op(input block_op_t item);
    int               hit_at;
    int               victim;
    int               n;
    logic [STAMP_W-1:0] best;
    logic             is_wr;
    result_t          r;
    r = '0;
    case (item.op)
      OP_READ, OP_WRITE: begin
        is_wr = (item.op == OP_WRITE);
        hit_at = -1;
        victim = 0;
        best = STAMP_TOP;
        for (int i = 0; i < NWAYS; i++) begin
          if (hit_at < 0) begin
            if (sh_valid[i] && sh_tag[i] == item.blk) begin
              hit_at = i;
            end else if (!sh_valid[i]) begin
              // last invalid slot wins
              victim = i;
              best = '0;
            end else if ((is_wr || !sh_dirty[i]) && sh_stamp[i] < best) begin
              victim = i;
              best = sh_stamp[i];
            end
          end
        end
        if (hit_at < 0) begin
          if (sh_valid[victim] && sh_dirty[victim]) begin
            r.wb = 1'b1;
            r.wb_block = sh_tag[victim];
          end
          r.fill = is_wr ? !item.full : 1'b1;
          sh_tag[victim] = item.blk;
          sh_valid[victim] = 1'b1;
          sh_dirty[victim] = 1'b0;
          hit_at = victim;
        end else begin
          r.hit = 1'b1;
        end
        sh_clock = sh_clock + 1'b1;
        sh_stamp[hit_at] = sh_clock;
        if (is_wr) sh_dirty[hit_at] = 1'b1;
        r.slot = hit_at[SLOT_W-1:0];
        r.last = 1'b1;
        pending_results.push_back(item.typed ? item.want : r);
      end
      OP_FLUSH: begin
        n = pending_results.size();
        for (int i = 0; i < NWAYS; i++) begin
          if (sh_valid[i] && sh_dirty[i]) begin
            r = '0;
            r.slot = i[SLOT_W-1:0];
            r.wb = 1'b1;
            r.wb_block = sh_tag[i];
            sh_dirty[i] = 1'b0;
            pending_results.push_back(r);
          end
        end
        if (pending_results.size() > n) begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      default: begin
        // tags survive an invalidate, nothing else does
        for (int i = 0; i < NWAYS; i++) begin
          sh_valid[i] = 1'b0;
          sh_dirty[i] = 1'b0;
          sh_stamp[i] = '0;
        end
        sh_clock = '0;
      end
    endcase
  endfunction

  function automatic void check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result with no item pending: slot %0d", got.slot);
      err_cnt++;
      return;
    end
    want = pending_results.pop_front();
    if (got.hit !== want.hit) begin
      $error("hit: expected %0d, got %0d", want.hit, got.hit);
      err_cnt++;
    end
    if (got.slot !== want.slot) begin
      $error("slot: expected %0d, got %0d", want.slot, got.slot);
      err_cnt++;
    end
    if (got.wb !== want.wb) begin
      $error("writeback_needed: expected %0d, got %0d", want.wb, got.wb);
      err_cnt++;
    end
    if (got.wb_block !== want.wb_block) begin
      $error("writeback_block: expected %h, got %h", want.wb_block, got.wb_block);
      err_cnt++;
    end
    if (got.fill !== want.fill) begin
      $error("fill_needed: expected %0d, got %0d", want.fill, got.fill);
      err_cnt++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      err_cnt++;
    end
  endfunction

  // Both channels and the watchdog in one process, so returned results are
  // always checked before accepted items are predicted.
  always @(posedge clk_i) begin
    logic nxt_valid;
    logic nxt_stall;
    logic busy;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      busy = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        // a result with nothing pending is not progress
        if (pending_results.size() != 0) busy = 1'b1;
        check_result({hit_o, slot_o, writeback_needed_o, writeback_block_o,
                      fill_needed_o, last_o});
      end
      if (in_valid_i && !in_stall_o) begin
        track_block_op(cur_op);
        nxt_valid = 1'b0;
        in_gap = pick_gap(0);
        busy = 1'b1;
      end
      if (!nxt_valid && stim_q.size() != 0) begin
        if (in_gap > 0) begin
          in_gap--;
        end else begin
          cur_op = stim_q.pop_front();
          nxt_valid = 1'b1;
          opcode_i <= cur_op.op;
          block_number_i <= cur_op.blk;
          full_block_i <= cur_op.full;
        end
      end
      in_valid_i <= nxt_valid;

      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else begin
        nxt_stall = 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap(1);
      end
      out_stall_i <= nxt_stall;

      if (busy) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) timed_out = 1'b1;
      drained = (stim_q.size() == 0) && !nxt_valid && (pending_results.size() == 0);
    end
  end

  initial begin
    block_op_t        item;
    logic [TAG_W-1:0] tag_pool[POOL_SIZE];
    int               made;
    int               seg_len;
    int               write_pct;
    int               pool_n;
    int               r;

    dir_tbl = '{
      row(OP_READ,  '0,        1'b1, 1'b1, 1'b0, 4'd15, 1'b1),  // full ignored on read
      row(OP_WRITE, TAG_MAX,   1'b1, 1'b1, 1'b0, 4'd14, 1'b0),
      row(OP_WRITE, '0,        1'b0, 1'b1, 1'b1, 4'd15, 1'b0),
      row(OP_READ,  TAG_MAX,   1'b0, 1'b1, 1'b1, 4'd14, 1'b0),
      row(OP_WRITE, TAG_FIVES, 1'b0, 1'b1, 1'b0, 4'd13, 1'b1),
      row(OP_WRITE, TAG_TENS,  1'b1, 1'b1, 1'b0, 4'd12, 1'b0),
      row(OP_FLUSH, TAG_MAX,   1'b1, 1'b0, 1'b0, 4'd0,  1'b0),
      row(OP_FLUSH, '0,        1'b0, 1'b0, 1'b0, 4'd0,  1'b0),  // nothing dirty
      row(OP_READ,  TAG_FIVES, 1'b1, 1'b1, 1'b1, 4'd13, 1'b0),
      row(OP_INVAL, TAG_MAX,   1'b1, 1'b0, 1'b0, 4'd0,  1'b0),
      row(OP_READ,  TAG_MAX,   1'b0, 1'b1, 1'b0, 4'd15, 1'b1),  // kept tag, no hit
      row(OP_WRITE, 52'd1,     1'b0, 1'b1, 1'b0, 4'd14, 1'b1),
      row(OP_FLUSH, TAG_TENS,  1'b0, 1'b0, 1'b0, 4'd0,  1'b0),
      row(OP_WRITE, 52'd2,     1'b1, 1'b1, 1'b0, 4'd13, 1'b0),
      row(OP_INVAL, '0,        1'b0, 1'b0, 1'b0, 4'd0,  1'b0),
      row(OP_FLUSH, TAG_FIVES, 1'b1, 1'b0, 1'b0, 4'd0,  1'b0)
    };
    foreach (dir_tbl[k]) stim_q.push_back(dir_tbl[k]);

    for (int k = 0; k < POOL_SIZE; k++) tag_pool[k] = rand_tag();
    tag_pool[0] = '0;
    tag_pool[1] = TAG_MAX;

    // Segments lean toward writes, reads or a mix; small tag pools give
    // many hits, large ones keep evicting, write-heavy runs fill every slot
    // dirty so read misses hit the fallback.
    made = 0;
    while (made < RAND_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       write_pct = 85;
        1:       write_pct = 20;
        default: write_pct = 50;
      endcase
      seg_len = $urandom_range(10, 40);
      pool_n = $urandom_range(4, POOL_SIZE);
      for (int k = 0; k < seg_len && made < RAND_ITEMS; k++) begin
        item = '0;
        if ($urandom_range(0, 99) < 85) item.blk = tag_pool[$urandom_range(0, pool_n - 1)];
        else item.blk = rand_tag();
        item.full = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 4) item.op = OP_FLUSH;
        else if (r < 6) item.op = OP_INVAL;
        else if ($urandom_range(0, 99) < write_pct) item.op = OP_WRITE;
        else item.op = OP_READ;
        stim_q.push_back(item);
        made++;
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (drained || timed_out);
    if (timed_out) begin
      $display("status: fail");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (err_cnt == 0 && pending_results.size() == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
    end
    $finish;
  end

endmodule
